@@ hdl/sequential_list_engine_macros.svh @@
// Assertion macros shared by the checker files of the list engine.
`ifndef SEQUENTIAL_LIST_ENGINE_MACROS_SVH
`define SEQUENTIAL_LIST_ENGINE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SLE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SLE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/slist_pkg.sv @@
// Types, codes and sizing constants of the sequential list engine.
package slist_pkg;

    localparam int CAPACITY   = 64;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);

    localparam logic [2:0] OP_APPEND       = 3'd0;
    localparam logic [2:0] OP_PREPEND      = 3'd1;
    localparam logic [2:0] OP_REMOVE_LAST  = 3'd2;
    localparam logic [2:0] OP_REMOVE_FIRST = 3'd3;
    localparam logic [2:0] OP_FIND         = 3'd4;
    localparam logic [2:0] OP_REMOVE_AT    = 3'd5;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_FULL      = 3'd1;
    localparam logic [2:0] ST_EMPTY     = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_RANGE     = 3'd4;

    typedef struct packed {
        logic [2:0]         op;
        logic signed [31:0] value;
        logic [5:0]         position;
    } cmd_t;

    typedef struct packed {
        logic [2:0]         status;
        logic signed [31:0] data;
        logic [6:0]         found_index;
        logic [6:0]         count;
    } rsp_t;

    typedef struct packed {
        logic                  we;
        logic [IDX_W-1:0]      waddr;
        logic [DATA_WIDTH-1:0] wdata;
        logic                  re;
        logic [IDX_W-1:0]      raddr;
    } ram_req_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP,
        S_PUT0,
        S_DOWN,
        S_FIND,
        S_DONE
    } state_t;

endpackage

@@ hdl/slist_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
module slist_ram #(
    parameter int DEPTH  = 64,
    parameter int WIDTH  = 32,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ hdl/slist_ctrl.sv @@
// Sequencer that walks the element memory for each list operation.
module slist_ctrl (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cmd_valid,
    input  slist_pkg::cmd_t                    cmd,
    output logic                               busy,
    output slist_pkg::ram_req_t                ram_req,
    input  logic [slist_pkg::DATA_WIDTH-1:0]   ram_rdata,
    output logic                               res_valid,
    input  logic                               res_ready,
    output slist_pkg::rsp_t                    res
);

    slist_pkg::state_t state_reg, state_next;

    logic [slist_pkg::DATA_WIDTH-1:0] val_reg, val_next;
    logic [slist_pkg::DATA_WIDTH-1:0] data_reg, data_next;
    logic [slist_pkg::IDX_W-1:0]      ptr_reg, ptr_next;
    logic [slist_pkg::CNT_W-1:0]      cnt_reg, cnt_next;
    logic [slist_pkg::CNT_W-1:0]      found_reg, found_next;
    logic [2:0]                       status_reg, status_next;
    logic                             first_reg, first_next;

    logic                             full;
    logic                             empty;
    logic                             more;
    logic                             match;
    logic                             pos_bad;
    logic [slist_pkg::IDX_W-1:0]      last_idx;

    assign full     = (cnt_reg == slist_pkg::CNT_W'(slist_pkg::CAPACITY));
    assign empty    = (cnt_reg == '0);
    assign more     = ((slist_pkg::CNT_W'(ptr_reg) + slist_pkg::CNT_W'(1)) < cnt_reg);
    assign match    = (ram_rdata == val_reg);
    assign pos_bad  = (slist_pkg::CNT_W'(cmd.position) >= cnt_reg);
    assign last_idx = slist_pkg::IDX_W'(cnt_reg - slist_pkg::CNT_W'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= slist_pkg::S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg    <= val_next;
        data_reg   <= data_next;
        ptr_reg    <= ptr_next;
        found_reg  <= found_next;
        status_reg <= status_next;
        first_reg  <= first_next;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            slist_pkg::S_IDLE:
            begin
                if (cmd_valid)
                begin
                    unique case (cmd.op) inside
                        slist_pkg::OP_APPEND:
                            state_next = slist_pkg::S_DONE;
                        slist_pkg::OP_PREPEND:
                            state_next = (full || empty) ? slist_pkg::S_DONE : slist_pkg::S_UP;
                        slist_pkg::OP_REMOVE_LAST, slist_pkg::OP_REMOVE_FIRST:
                            state_next = empty ? slist_pkg::S_DONE : slist_pkg::S_DOWN;
                        slist_pkg::OP_FIND:
                            state_next = empty ? slist_pkg::S_DONE : slist_pkg::S_FIND;
                        slist_pkg::OP_REMOVE_AT:
                            state_next = pos_bad ? slist_pkg::S_DONE : slist_pkg::S_DOWN;
                        default:
                            state_next = slist_pkg::S_DONE;
                    endcase
                end
            end
            slist_pkg::S_UP:
                state_next = (ptr_reg == '0) ? slist_pkg::S_PUT0 : slist_pkg::S_UP;
            slist_pkg::S_PUT0:
                state_next = slist_pkg::S_DONE;
            slist_pkg::S_DOWN:
                state_next = more ? slist_pkg::S_DOWN : slist_pkg::S_DONE;
            slist_pkg::S_FIND:
                state_next = (match || !more) ? slist_pkg::S_DONE : slist_pkg::S_FIND;
            slist_pkg::S_DONE:
                state_next = res_ready ? slist_pkg::S_IDLE : slist_pkg::S_DONE;
            default:
                state_next = slist_pkg::S_IDLE;
        endcase
    end

    // Datapath updates and memory requests.
    always_comb
    begin
        val_next    = val_reg;
        data_next   = data_reg;
        ptr_next    = ptr_reg;
        cnt_next    = cnt_reg;
        found_next  = found_reg;
        status_next = status_reg;
        first_next  = first_reg;
        ram_req     = '0;

        unique case (state_reg)
            slist_pkg::S_IDLE:
            begin
                if (cmd_valid)
                begin
                    val_next    = slist_pkg::DATA_WIDTH'(cmd.value);
                    data_next   = '0;
                    found_next  = '0;
                    status_next = slist_pkg::ST_OK;
                    first_next  = 1'b1;
                    unique case (cmd.op) inside
                        slist_pkg::OP_APPEND:
                        begin
                            if (full)
                            begin
                                status_next = slist_pkg::ST_FULL;
                            end
                            else
                            begin
                                ram_req.we    = 1'b1;
                                ram_req.waddr = slist_pkg::IDX_W'(cnt_reg);
                                ram_req.wdata = slist_pkg::DATA_WIDTH'(cmd.value);
                                cnt_next      = cnt_reg + slist_pkg::CNT_W'(1);
                            end
                        end
                        slist_pkg::OP_PREPEND:
                        begin
                            if (full)
                            begin
                                status_next = slist_pkg::ST_FULL;
                            end
                            else if (empty)
                            begin
                                ram_req.we    = 1'b1;
                                ram_req.waddr = '0;
                                ram_req.wdata = slist_pkg::DATA_WIDTH'(cmd.value);
                                cnt_next      = cnt_reg + slist_pkg::CNT_W'(1);
                            end
                            else
                            begin
                                ram_req.re    = 1'b1;
                                ram_req.raddr = last_idx;
                                ptr_next      = last_idx;
                            end
                        end
                        slist_pkg::OP_REMOVE_LAST:
                        begin
                            if (empty)
                            begin
                                status_next = slist_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                ram_req.re    = 1'b1;
                                ram_req.raddr = last_idx;
                                ptr_next      = last_idx;
                            end
                        end
                        slist_pkg::OP_REMOVE_FIRST:
                        begin
                            if (empty)
                            begin
                                status_next = slist_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                ram_req.re = 1'b1;
                                ptr_next   = '0;
                            end
                        end
                        slist_pkg::OP_FIND:
                        begin
                            if (empty)
                            begin
                                status_next = slist_pkg::ST_NOT_FOUND;
                            end
                            else
                            begin
                                ram_req.re = 1'b1;
                                ptr_next   = '0;
                            end
                        end
                        slist_pkg::OP_REMOVE_AT:
                        begin
                            if (pos_bad)
                            begin
                                status_next = slist_pkg::ST_RANGE;
                            end
                            else
                            begin
                                ram_req.re    = 1'b1;
                                ram_req.raddr = slist_pkg::IDX_W'(cmd.position);
                                ptr_next      = slist_pkg::IDX_W'(cmd.position);
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            slist_pkg::S_UP:
            begin
                // The element read last cycle moves up one place while the next
                // lower one is read.
                ram_req.we    = 1'b1;
                ram_req.waddr = ptr_reg + slist_pkg::IDX_W'(1);
                ram_req.wdata = ram_rdata;
                if (ptr_reg != '0)
                begin
                    ram_req.re    = 1'b1;
                    ram_req.raddr = ptr_reg - slist_pkg::IDX_W'(1);
                    ptr_next      = ptr_reg - slist_pkg::IDX_W'(1);
                end
            end
            slist_pkg::S_PUT0:
            begin
                ram_req.we    = 1'b1;
                ram_req.waddr = '0;
                ram_req.wdata = val_reg;
                cnt_next      = cnt_reg + slist_pkg::CNT_W'(1);
            end
            slist_pkg::S_DOWN:
            begin
                // The first word read is the element removed; every later one
                // moves down one place.
                if (first_reg)
                begin
                    data_next  = ram_rdata;
                    first_next = 1'b0;
                end
                else
                begin
                    ram_req.we    = 1'b1;
                    ram_req.waddr = ptr_reg - slist_pkg::IDX_W'(1);
                    ram_req.wdata = ram_rdata;
                end
                if (more)
                begin
                    ram_req.re    = 1'b1;
                    ram_req.raddr = ptr_reg + slist_pkg::IDX_W'(1);
                    ptr_next      = ptr_reg + slist_pkg::IDX_W'(1);
                end
                else
                begin
                    cnt_next = cnt_reg - slist_pkg::CNT_W'(1);
                end
            end
            slist_pkg::S_FIND:
            begin
                if (match)
                begin
                    found_next = slist_pkg::CNT_W'(ptr_reg) + slist_pkg::CNT_W'(1);
                end
                else if (more)
                begin
                    ram_req.re    = 1'b1;
                    ram_req.raddr = ptr_reg + slist_pkg::IDX_W'(1);
                    ptr_next      = ptr_reg + slist_pkg::IDX_W'(1);
                end
                else
                begin
                    status_next = slist_pkg::ST_NOT_FOUND;
                end
            end
            slist_pkg::S_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    assign busy              = (state_reg != slist_pkg::S_IDLE);
    assign res_valid         = (state_reg == slist_pkg::S_DONE);
    assign res.status        = status_reg;
    assign res.data          = 32'(data_reg);
    assign res.found_index   = 7'(found_reg);
    assign res.count         = 7'(cnt_reg);

endmodule

@@ hdl/sequential_list_engine.sv @@
// Top level of the sequential list engine: sequencer, element memory, result register.
//
// A fixed-capacity array list (64 elements) kept packed from index 0. One
// command transfer on cmd/cmd_valid/cmd_stall carries an operation; exactly
// one response transfer on rsp/rsp_valid/rsp_stall follows for it, in order.
// Operations: append, prepend, remove last, remove first, find, remove at
// position. The response gives status, removed data, one-based find position
// and the element count after the operation.
// One command is worked at a time; cmd_stall is high while it is in flight.
// Append, unknown operations, prepend onto an empty list and every rejected
// command go straight to the response; prepend otherwise moves each element
// up one place from the top, then writes index 0; remove at position (remove
// last and remove first included) moves every later element down one place;
// find reads from index 0 until a match or the end of the list.
// The walk is paced by the element memory: one read and one write per cycle,
// with read data arriving in the cycle after its address.
// The response sits in an output register, so a stalled response holds while
// the engine already takes and works the next command; that command then
// waits to finish until the register frees.
// Reset empties the list (count zero); memory contents are not cleared.
module sequential_list_engine (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    output logic            cmd_stall,
    input  slist_pkg::cmd_t cmd,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output slist_pkg::rsp_t rsp
);

    slist_pkg::ram_req_t              ram_req;
    logic [slist_pkg::DATA_WIDTH-1:0] ram_rdata;
    logic                             busy;
    logic                             res_valid;
    logic                             res_ready;
    slist_pkg::rsp_t                  res;

    logic                             rsp_valid_reg, rsp_valid_next;
    slist_pkg::rsp_t                  rsp_reg, rsp_next;

    slist_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .busy      (busy),
        .ram_req   (ram_req),
        .ram_rdata (ram_rdata),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    slist_ram #(
        .DEPTH (slist_pkg::CAPACITY),
        .WIDTH (slist_pkg::DATA_WIDTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .re    (ram_req.re),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata)
    );

    assign res_ready = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        if (res_valid && res_ready)
        begin
            rsp_valid_next = 1'b1;
            rsp_next       = res;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign cmd_stall = busy;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

@@ hdl/sequential_list_engine_checker.sv @@
// Port-level checker for the sequential list engine, bound to the top level.
`include "sequential_list_engine_macros.svh"

module sequential_list_engine_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            cmd_valid,
    input logic            cmd_stall,
    input logic            rsp_valid,
    input logic            rsp_stall,
    input slist_pkg::rsp_t rsp
);

    `SLE_ASSERT_NEXT(a_cmd_busy, cmd_valid && !cmd_stall, cmd_stall, "command side open after a transfer")
    `SLE_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "stalled response transfer changed")
    `SLE_ASSERT_NOW(a_count_cap, rsp_valid, rsp.count <= 7'(slist_pkg::CAPACITY), "count exceeds capacity")
    `SLE_ASSERT_NOW(a_found_ok, rsp_valid && (rsp.found_index != '0), (rsp.status == slist_pkg::ST_OK) && (rsp.found_index <= rsp.count), "found position inconsistent with status or count")
    `SLE_ASSERT_NOW(a_empty_cnt, rsp_valid && (rsp.status == slist_pkg::ST_EMPTY), (rsp.count == '0) && (rsp.data == '0), "empty status with elements held")

endmodule

bind sequential_list_engine sequential_list_engine_checker u_checker (.*);
